### hdl/depthwise_dilated_causal_fir_defines.svh
// Assertion macros shared by the filter modules
`ifndef DEPTHWISE_DILATED_CAUSAL_FIR_DEFINES_SVH
`define DEPTHWISE_DILATED_CAUSAL_FIR_DEFINES_SVH
// antecedent implies consequent on the next edge
`define DDCF_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
// antecedent implies consequent on the same edge
`define DDCF_ASSERT_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`endif

### hdl/ddcf_pkg.sv
// Package: constants, types and helpers for the dilated causal FIR
`default_nettype none
package ddcf_pkg;
	localparam int MaxChannels  = 512;
	localparam int MaxTaps      = 8;
	localparam int MaxDilation  = 4;
	localparam int HistoryDepth = 32;
	localparam int ChW   = $clog2(MaxChannels);
	localparam int TapW  = $clog2(MaxTaps);
	localparam int HistW = $clog2(HistoryDepth);
	localparam int SeenW = 6;
	localparam logic [SeenW-1:0] SeenLimit = 6'd63;
	localparam int AccW  = 40;

	localparam logic [1:0] ModeWeight = 2'd0;
	localparam logic [1:0] ModeBias   = 2'd1;
	localparam logic [1:0] ModeSample = 2'd2;
	localparam logic [1:0] ModeUnused = 2'd3;

	localparam logic [1:0] RegKernelSize   = 2'd0;
	localparam logic [1:0] RegTapSpacing   = 2'd1;
	localparam logic [1:0] RegChannelsUsed = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [8:0]  channel;
		logic [2:0]  tap;
		logic signed [15:0] value;
		logic        restart;
	} in_word_t;

	typedef struct packed {
		logic [8:0]  out_channel;
		logic signed [15:0] out_value;
		logic        saturated;
	} out_word_t;

	// controller -> datapath
	typedef struct packed {
		logic clr;       // zero one position/seen entry after reset
		logic latch;     // capture input word, start lookups
		logic store;     // write weight or bias of the latched word
		logic write_hist;// write sample into ring, update position/seen
		logic clear_acc; // load bias into accumulator
		logic tap_rd;    // issue weight/history read for tap_idx
		logic mac;       // accumulate registered product
		logic finish;    // round and saturate into output register
		logic [TapW-1:0] tap_idx;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [TapW:0] ks; // taps in use, 1..MaxTaps
		logic is_sample;
		logic in_range;
		logic clr_done;
	} stat_t;
endpackage
`default_nettype wire

### hdl/ddcf_stream_if.sv
// Valid/ready stream interface carrying one word
`default_nettype none
interface ddcf_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/ddcf_ctrl.sv
// Controller: lookup per word; in-range samples then run taps and output
`default_nettype none
`include "depthwise_dilated_causal_fir_defines.svh"
module ddcf_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic out_full,
	input  wire ddcf_pkg::stat_t stat,
	output ddcf_pkg::cmd_t cmd
);
	typedef enum logic [7:0] {
		S_CLR   = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_DEC   = 8'b00000100,
		S_HIST  = 8'b00001000,
		S_TAP   = 8'b00010000,
		S_MUL   = 8'b00100000,
		S_DRAIN = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic [ddcf_pkg::TapW:0] idx_q, idx_d;
	logic [1:0] drain_q, drain_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		drain_d = drain_q;
		cmd     = '0;
		cmd.tap_idx = idx_q[ddcf_pkg::TapW-1:0];
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				// bias/ring reads at the latched channel land this edge
				cmd.store = 1'b1;
				if (stat.in_range && stat.is_sample) begin
					state_d = S_HIST;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_HIST: begin
				cmd.write_hist = 1'b1;
				cmd.clear_acc  = 1'b1;
				idx_d   = '0;
				state_d = S_TAP;
			end
			S_TAP: begin
				cmd.tap_rd = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				// read data valid: product is registered this edge
				idx_d = idx_q + 1'b1;
				if (idx_q + 1'b1 < stat.ks) begin
					state_d = S_TAP;
				end else begin
					drain_d = 2'd0;
					state_d = S_DRAIN;
				end
				if (idx_q != '0) cmd.mac = 1'b1;
			end
			S_DRAIN: begin
				cmd.mac = (drain_q == 2'd0);
				drain_d = drain_q + 1'b1;
				if (drain_q == 2'd1) state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_full) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q   <= '0;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			drain_q <= drain_d;
		end
	end

	`DDCF_ASSERT_NEXT(a_latch_dec, clk, arst_n, cmd.latch, state_q == S_DEC)
	`DDCF_ASSERT_SAME(a_one_hot, clk, arst_n, 1'b1, $onehot(state_q))
	`DDCF_ASSERT_SAME(a_finish_room, clk, arst_n, cmd.finish, !out_full)
	`DDCF_ASSERT_SAME(a_idx_range, clk, arst_n, state_q == S_TAP, idx_q < stat.ks)
endmodule
`default_nettype wire

### hdl/ddcf_datapath.sv
// Datapath: memories, per-channel ring state, MAC, rounding and output register
`default_nettype none
`include "depthwise_dilated_causal_fir_defines.svh"
module ddcf_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ddcf_pkg::in_word_t in_word,
	input  wire ddcf_pkg::cmd_t cmd,
	input  wire logic [3:0] kernel_size,
	input  wire logic [2:0] tap_spacing,
	input  wire logic [9:0] channels_used,
	output ddcf_pkg::stat_t stat,
	output logic out_valid,
	input  wire logic out_ready,
	output ddcf_pkg::out_word_t out_word
);
	localparam int ChW = ddcf_pkg::ChW;
	localparam int TapW = ddcf_pkg::TapW;
	localparam int HistW = ddcf_pkg::HistW;
	localparam int SeenW = ddcf_pkg::SeenW;
	localparam int AccW = ddcf_pkg::AccW;

	logic [15:0] weight_mem [ddcf_pkg::MaxChannels*ddcf_pkg::MaxTaps];
	logic [15:0] bias_mem   [ddcf_pkg::MaxChannels];
	logic [15:0] hist_mem   [ddcf_pkg::MaxChannels*ddcf_pkg::HistoryDepth];
	logic [HistW+SeenW-1:0] ptr_mem [ddcf_pkg::MaxChannels];
	logic [ChW-1:0] clr_q;

	ddcf_pkg::in_word_t word_q;
	logic [15:0] bias_rd_q;
	logic [HistW+SeenW-1:0] ptr_rd_q;
	logic [HistW-1:0] pos_q;
	logic [SeenW-1:0] seen_q;
	logic [15:0] w_rd_q, h_rd_q;
	logic signed [31:0] prod_q;
	logic signed [AccW-1:0] acc_q;
	logic [TapW:0] ks;
	logic [2:0] sp;
	logic [10:0] used;
	logic [HistW-1:0] pos_cur;
	logic [SeenW-1:0] seen_cur, seen_new;
	logic [ChW+TapW-1:0] w_addr;
	logic [ChW+HistW-1:0] h_addr;
	logic [6:0] delay_raw, delay;
	logic [HistW-1:0] slot;
	logic signed [AccW-1:0] rnd;
	logic signed [AccW-15:0] r;
	logic sample_now;
	logic [15:0] hist_val;

	assign ks = (kernel_size == 4'd0) ? 4'd1 :
		(kernel_size > 4'(ddcf_pkg::MaxTaps)) ? 4'(ddcf_pkg::MaxTaps) : kernel_size;
	assign sp = (tap_spacing == 3'd0) ? 3'd1 :
		(tap_spacing > 3'(ddcf_pkg::MaxDilation)) ? 3'(ddcf_pkg::MaxDilation) : tap_spacing;
	assign used = (channels_used > 10'(ddcf_pkg::MaxChannels)) ?
		11'(ddcf_pkg::MaxChannels) : {1'b0, channels_used};

	assign stat.ks = ks;
	assign stat.is_sample = (word_q.mode == ddcf_pkg::ModeSample);
	assign stat.in_range = ({2'b0, word_q.channel} < used);
	assign stat.clr_done = (clr_q == ChW'(ddcf_pkg::MaxChannels - 1));

	// per-channel position/seen, zeroed by the pass after reset
	assign pos_cur  = ptr_rd_q[HistW+SeenW-1:SeenW];
	assign seen_cur = word_q.restart ? '0 : ptr_rd_q[SeenW-1:0];
	assign seen_new = (seen_cur == ddcf_pkg::SeenLimit) ? seen_cur : seen_cur + 1'b1;

	// delay for current tap, clamped to history seen and ring depth
	assign delay_raw = (7'(ks) - 7'd1 - 7'(cmd.tap_idx)) * 7'(sp);
	always_comb begin
		delay = delay_raw;
		if (delay > 7'(seen_q - 1'b1)) delay = 7'(seen_q - 1'b1);
		if (delay > 7'(ddcf_pkg::HistoryDepth - 1)) delay = 7'(ddcf_pkg::HistoryDepth - 1);
	end
	assign slot = pos_q - delay[HistW-1:0];
	assign w_addr = {word_q.channel, cmd.tap_idx};
	assign h_addr = {word_q.channel, slot};
	assign sample_now = (word_q.mode == ddcf_pkg::ModeSample);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			word_q <= in_word;
		end
		// stage-one reads at the latched channel
		bias_rd_q <= bias_mem[word_q.channel];
		ptr_rd_q  <= ptr_mem[word_q.channel];
		if (cmd.store && stat.in_range && word_q.mode == ddcf_pkg::ModeWeight) begin
			weight_mem[{word_q.channel, word_q.tap}] <= word_q.value;
		end
		if (cmd.store && stat.in_range && word_q.mode == ddcf_pkg::ModeBias) begin
			bias_mem[word_q.channel] <= word_q.value;
		end
		if (cmd.clr) begin
			ptr_mem[clr_q] <= '0;
		end else if (cmd.write_hist) begin
			ptr_mem[word_q.channel] <= {HistW'(pos_cur + 1'b1), seen_new};
		end
		if (cmd.write_hist) begin
			hist_mem[{word_q.channel, pos_cur}] <= word_q.value;
			pos_q  <= pos_cur;
			seen_q <= seen_new;
		end
		if (cmd.tap_rd) begin
			w_rd_q <= weight_mem[w_addr];
			h_rd_q <= hist_mem[h_addr];
		end
		prod_q <= $signed(w_rd_q) * $signed(hist_val);
	end
	assign hist_val = h_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_acc) begin
			acc_q <= AccW'($signed(bias_rd_q)) <<< 14;
		end else if (cmd.mac) begin
			acc_q <= acc_q + AccW'(prod_q);
		end
	end

	assign rnd = acc_q + AccW'(8192);
	assign r = rnd[AccW-1:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_word.out_channel <= word_q.channel;
			if (r > 32767) begin
				out_word.out_value <= 16'sh7fff;
				out_word.saturated <= 1'b1;
			end else if (r < -32768) begin
				out_word.out_value <= 16'sh8000;
				out_word.saturated <= 1'b1;
			end else begin
				out_word.out_value <= r[15:0];
				out_word.saturated <= 1'b0;
			end
		end
	end

	`DDCF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`DDCF_ASSERT_SAME(a_ks_range, clk, arst_n, 1'b1, ks != '0)
	`DDCF_ASSERT_SAME(a_hist_sample, clk, arst_n, cmd.write_hist, sample_now)
endmodule
`default_nettype wire

### hdl/depthwise_dilated_causal_fir.sv
// Each word is decoded; an in-range sample then writes history, reads one
// weight/history pair per tap, registers the product and drains the MAC into
// the output register, waiting while it is full. One word is taken at a time.
// Reset (arst_n low, async): control clears, registers return to 7/1/512, then a
// pass zeroes all 512 per-channel ring positions and sample counts (input not
// ready meanwhile); weights, biases and history are undefined until written.
`default_nettype none
module depthwise_dilated_causal_fir (
	input  wire logic clk,
	input  wire logic arst_n,
	ddcf_stream_if.sink   in_s,
	ddcf_stream_if.source out_s,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [9:0] cfg_data
);
	logic [3:0] kernel_size_q;
	logic [2:0] tap_spacing_q;
	logic [9:0] channels_used_q;
	ddcf_pkg::cmd_t  cmd;
	ddcf_pkg::stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_size_q   <= 4'd7;
			tap_spacing_q   <= 3'd1;
			channels_used_q <= 10'd512;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ddcf_pkg::RegKernelSize:   kernel_size_q <= cfg_data[3:0];
				ddcf_pkg::RegTapSpacing:   tap_spacing_q <= cfg_data[2:0];
				ddcf_pkg::RegChannelsUsed: channels_used_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ddcf_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_s.valid), .in_ready(in_s.ready),
		.out_full(out_s.valid && !out_s.ready),
		.stat, .cmd
	);

	ddcf_datapath u_dp (
		.clk, .arst_n,
		.in_word(in_s.data), .cmd,
		.kernel_size(kernel_size_q), .tap_spacing(tap_spacing_q),
		.channels_used(channels_used_q),
		.stat,
		.out_valid(out_s.valid), .out_ready(out_s.ready), .out_word(out_s.data)
	);
endmodule
`default_nettype wire
